// ----- rtl/egnms_pkg.sv -----
// Shared constants and types for the edge gradient / non-maximum suppression block.
// No dependencies; every other file refers to it by scoped names.
package egnms_pkg;

  localparam int PIX_W      = 12;
  localparam int GRAD_W     = PIX_W + 1;
  localparam int MAG_W      = 13;
  localparam int DIR_W      = 2;
  localparam int RAD_W      = 2 * MAG_W;
  localparam int SQ_CNT_W   = $clog2(MAG_W);
  localparam int CFG_W_W    = 11;
  localparam int HGT_W      = 12;
  localparam int CFG_DATA_W = 12;
  localparam int MIN_DIM    = 3;

  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIR_W-1:0] DIR_0   = 2'd0;
  localparam logic [DIR_W-1:0] DIR_45  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_90  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_135 = 2'd3;

  typedef struct packed {
    logic gx_ok;
    logic gy_ok;
  } grad_guard_t;

endpackage

// ----- rtl/egnms_grad.sv -----
// Pixel line memory (two previous rows per column), 3x3 pixel window,
// central-difference gradient, squares and direction sector. Uses egnms_pkg.
module egnms_grad #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic                             shift,
  input  logic                             calc,
  input  logic [AW-1:0]                    addr,
  input  logic [egnms_pkg::PIX_W-1:0]      pixel,
  input  egnms_pkg::grad_guard_t           guard,
  output logic [egnms_pkg::RAD_W-1:0]      radicand,
  output logic [egnms_pkg::DIR_W-1:0]      dir
);

  localparam int PW = egnms_pkg::PIX_W;
  localparam int GW = egnms_pkg::GRAD_W;

  // hi half: row above, lo half: two rows above
  logic [2*PW-1:0] line_mem [DEPTH];
  logic [2*PW-1:0] rd_q;

  logic [PW-1:0] mid0_r, mid1_r, mid2_r, top1_r, top2_r, bot1_r, bot2_r;

  logic signed [GW-1:0] gx, gy;
  logic [PW-1:0]        ax, ay, dif;
  logic [GW-1:0]        sum;
  logic [2*PW-1:0]      sx_r, sy_r, pdif_r;
  logic [2*GW-1:0]      psum_r;
  logic                 gx_zero_r, gy_zero_r, vpos_r, ule_r;
  logic [2*PW:0]        twice;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= line_mem[addr];
    end
    if (shift) begin
      line_mem[addr] <= {pixel, rd_q[2*PW-1:PW]};
      mid0_r <= mid1_r;
      mid1_r <= mid2_r;
      mid2_r <= rd_q[2*PW-1:PW];
      top1_r <= top2_r;
      top2_r <= rd_q[PW-1:0];
      bot1_r <= bot2_r;
      bot2_r <= pixel;
    end
  end

  always_comb begin
    gx = '0;
    gy = '0;
    if (guard.gx_ok) gx = $signed({1'b0, mid2_r}) - $signed({1'b0, mid0_r});
    if (guard.gy_ok) gy = $signed({1'b0, bot1_r}) - $signed({1'b0, top1_r});
  end

  assign ax  = gx[GW-1] ? PW'(-gx) : PW'(gx);
  assign ay  = gy[GW-1] ? PW'(-gy) : PW'(gy);
  assign sum = {1'b0, ax} + {1'b0, ay};
  assign dif = (ay > ax) ? (ay - ax) : '0;

  always_ff @(posedge clk) begin
    if (calc) begin
      sx_r      <= ax * ax;
      sy_r      <= ay * ay;
      psum_r    <= sum * sum;
      pdif_r    <= dif * dif;
      gx_zero_r <= (gx == '0);
      gy_zero_r <= (gy == '0);
      // sign of the horizontal term after folding the vector into the upper half-plane
      vpos_r    <= (gy > 0) ? (gx < 0) : (gx > 0);
      ule_r     <= (ay <= ax);
    end
  end

  assign twice    = {sx_r, 1'b0};
  assign radicand = egnms_pkg::RAD_W'(sx_r) + egnms_pkg::RAD_W'(sy_r);

  always_comb begin
    if (gy_zero_r) begin
      dir = egnms_pkg::DIR_0;
    end else if (gx_zero_r) begin
      dir = egnms_pkg::DIR_90;
    end else if (psum_r <= (2*GW)'(twice)) begin
      dir = egnms_pkg::DIR_0;
    end else if (ule_r || ((2*PW+1)'(pdif_r) <= twice)) begin
      dir = vpos_r ? egnms_pkg::DIR_45 : egnms_pkg::DIR_135;
    end else begin
      dir = egnms_pkg::DIR_90;
    end
  end

endmodule

// ----- rtl/egnms_isqrt.sv -----
// Iterative integer square root, one result bit per cycle.
// Uses egnms_pkg for widths.
module egnms_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [egnms_pkg::RAD_W-1:0]  radicand,
  output logic [egnms_pkg::MAG_W-1:0]  root,
  output logic                         done
);

  localparam int MW = egnms_pkg::MAG_W;
  localparam int RW = egnms_pkg::RAD_W;
  localparam int CW = egnms_pkg::SQ_CNT_W;

  logic [RW-1:0] rad_r;
  logic [MW-1:0] root_r;
  logic [MW:0]   rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;

  logic [MW+2:0] rem_sh, trial;

  assign rem_sh = {rem_r, rad_r[RW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MW - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= (MW+1)'(rem_sh - trial);
        root_r <= {root_r[MW-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[MW:0];
        root_r <= {root_r[MW-2:0], 1'b0};
      end
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

// ----- rtl/egnms_nms.sv -----
// Magnitude/direction line memory, 3x3 magnitude window and the
// non-maximum suppression compare. Uses egnms_pkg.
module egnms_nms #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic                         shift,
  input  logic [AW-1:0]                addr,
  input  logic [egnms_pkg::MAG_W-1:0]  mag,
  input  logic [egnms_pkg::DIR_W-1:0]  dir,
  input  logic                         interior,
  output logic [egnms_pkg::MAG_W-1:0]  edge_mag,
  output logic [egnms_pkg::DIR_W-1:0]  edge_dir
);

  localparam int MW = egnms_pkg::MAG_W;
  localparam int DW = egnms_pkg::DIR_W;
  localparam int EW = 2 * MW + DW;

  // {row above magnitude, row above direction, two rows above magnitude}
  logic [EW-1:0] line_mem [DEPTH];
  logic [EW-1:0] rd_q;

  logic [MW-1:0] top_r [3];
  logic [MW-1:0] mid_r [3];
  logic [MW-1:0] bot_r [3];
  logic [DW-1:0] dir1_r, dir2_r;

  logic [MW-1:0] n1, n2, centre;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= line_mem[addr];
    end
    if (shift) begin
      line_mem[addr] <= {mag, dir, rd_q[EW-1 -: MW]};
      top_r[0] <= top_r[1];
      top_r[1] <= top_r[2];
      top_r[2] <= rd_q[MW-1:0];
      mid_r[0] <= mid_r[1];
      mid_r[1] <= mid_r[2];
      mid_r[2] <= rd_q[EW-1 -: MW];
      bot_r[0] <= bot_r[1];
      bot_r[1] <= bot_r[2];
      bot_r[2] <= mag;
      dir1_r   <= dir2_r;
      dir2_r   <= rd_q[MW +: DW];
    end
  end

  assign centre = mid_r[1];

  always_comb begin
    case (dir1_r)
      egnms_pkg::DIR_0: begin
        n1 = mid_r[2];
        n2 = mid_r[0];
      end
      egnms_pkg::DIR_45: begin
        n1 = top_r[2];
        n2 = bot_r[0];
      end
      egnms_pkg::DIR_90: begin
        n1 = top_r[1];
        n2 = bot_r[1];
      end
      default: begin
        n1 = top_r[0];
        n2 = bot_r[2];
      end
    endcase
  end

  assign edge_mag = (interior && !(centre > n1 && centre > n2)) ? '0 : centre;
  assign edge_dir = dir1_r;

endmodule

// ----- rtl/edge_gradient_nonmax_suppress_core.sv -----
// Top level of the gradient and non-maximum suppression block: control sequencer,
// frame counters, configuration and output register. Uses egnms_pkg, egnms_grad,
// egnms_isqrt and egnms_nms.
//
// Usage: pixels enter in raster order on the in_ channel (valid/ready). The first
// pixel of a frame latches frame_width (clamped to 3..MAX_WIDTH) and frame_height
// (at least 3); write those via cfg_ only while the block is idle. The result for a
// pixel comes out after the pixel two rows and two columns later has been taken;
// once the last pixel of a frame is in, each item with in_drain set releases one
// pending result, and out_last_of_frame marks the final one. A drain item outside
// that window is taken and dropped.
// Throughput: one item at a time. An item that produces a gradient passes READ, PIX,
// GRAD, START, the 13-step bit-serial square root (ROOT), MAG and, if due, EMIT; the first
// width+1 items of a frame pass only READ and PIX. Line memories have a registered read.
// Reset (synchronous, rst_n low) clears control state and restores both frame
// registers to 512. A stalled result waits in the output register; the next item
// is still taken and runs until it needs that register.
module edge_gradient_nonmax_suppress_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [0:0]                        cfg_index,
  input  logic [egnms_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [egnms_pkg::PIX_W-1:0]       in_pixel_value,
  input  logic                              in_drain,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [egnms_pkg::MAG_W-1:0]       out_edge_magnitude,
  output logic [egnms_pkg::DIR_W-1:0]       out_direction,
  output logic                              out_last_of_frame
);

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WL_W = $clog2(MAX_WIDTH + 1);
  localparam int HW   = egnms_pkg::HGT_W;
  localparam int NW   = WL_W + HW + 1;
  localparam int GRW  = HW + 1;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_READ  = 8'b0000_0010,
    ST_PIX   = 8'b0000_0100,
    ST_GRAD  = 8'b0000_1000,
    ST_START = 8'b0001_0000,
    ST_ROOT  = 8'b0010_0000,
    ST_MAG   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [egnms_pkg::CFG_W_W-1:0] frame_width_r;
  logic [HW-1:0]                 frame_height_r;
  logic [WL_W-1:0]               lat_w_r, lat_w_nxt;
  logic [HW-1:0]                 lat_h_r, lat_h_nxt;
  logic [NW-1:0]                 total_r, n_r;
  logic [AW-1:0]                 cn_r, gc_r, kc_r;
  logic [GRW-1:0]                gr_r;
  logic [HW-1:0]                 kr_r;
  logic                          active_r;
  logic [egnms_pkg::PIX_W-1:0]   pix_r;

  logic [egnms_pkg::MAG_W-1:0]   out_mag_r;
  logic [egnms_pkg::DIR_W-1:0]   out_dir_r;
  logic                          out_last_r, out_valid_r;

  logic in_xfer, all_in, new_frame, flushable, gval, emit_now, finish, load_out;
  logic cn_last, gc_last, kc_last, k_last, interior;

  egnms_pkg::grad_guard_t        guard;
  logic [egnms_pkg::RAD_W-1:0]   radicand;
  logic [egnms_pkg::DIR_W-1:0]   grad_dir, edge_dir;
  logic [egnms_pkg::MAG_W-1:0]   root, edge_mag;
  logic                          sq_done;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign all_in    = (n_r >= total_r);
  assign new_frame = !active_r || all_in;
  assign flushable = active_r && all_in;
  assign gval      = (n_r >= NW'(lat_w_r) + NW'(1));
  assign emit_now  = (n_r >= (NW'(lat_w_r) << 1) + NW'(2));

  assign cn_last = (WL_W'(cn_r) == lat_w_r - WL_W'(1));
  assign gc_last = (WL_W'(gc_r) == lat_w_r - WL_W'(1));
  assign kc_last = (WL_W'(kc_r) == lat_w_r - WL_W'(1));
  assign k_last  = kc_last && (kr_r == lat_h_r - HW'(1));

  assign guard.gx_ok = (gc_r != '0) && (WL_W'(gc_r) + WL_W'(1) < lat_w_r);
  assign guard.gy_ok = (gr_r != '0) && (gr_r + GRW'(1) < GRW'(lat_h_r));
  assign interior    = (kr_r != '0) && (kr_r + HW'(1) < lat_h_r) &&
                       (kc_r != '0) && (WL_W'(kc_r) + WL_W'(1) < lat_w_r);

  assign load_out = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign finish   = ((state_r == ST_PIX) && !gval) ||
                    ((state_r == ST_MAG) && !emit_now) || load_out;

  // clamp the frame size at the start of a frame
  always_comb begin
    if (frame_width_r < egnms_pkg::CFG_W_W'(egnms_pkg::MIN_DIM)) begin
      lat_w_nxt = WL_W'(egnms_pkg::MIN_DIM);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      lat_w_nxt = WL_W'(MAX_WIDTH);
    end else begin
      lat_w_nxt = WL_W'(frame_width_r);
    end
    if (frame_height_r < HW'(egnms_pkg::MIN_DIM)) begin
      lat_h_nxt = HW'(egnms_pkg::MIN_DIM);
    end else begin
      lat_h_nxt = frame_height_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (!in_drain || flushable)) state_nxt = ST_READ;
      end
      ST_READ:  state_nxt = ST_PIX;
      ST_PIX:   state_nxt = gval ? ST_GRAD : ST_IDLE;
      ST_GRAD:  state_nxt = ST_START;
      ST_START: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (sq_done) state_nxt = ST_MAG;
      end
      ST_MAG:   state_nxt = emit_now ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      frame_width_r  <= egnms_pkg::CFG_W_W'(512);
      frame_height_r <= HW'(512);
      lat_w_r        <= WL_W'(egnms_pkg::MIN_DIM);
      lat_h_r        <= HW'(egnms_pkg::MIN_DIM);
      total_r        <= '0;
      n_r            <= '0;
      cn_r           <= '0;
      gc_r           <= '0;
      gr_r           <= '0;
      kc_r           <= '0;
      kr_r           <= '0;
      active_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          egnms_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[egnms_pkg::CFG_W_W-1:0];
          egnms_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[HW-1:0];
        endcase
      end

      if (in_xfer && !in_drain && new_frame) begin
        lat_w_r  <= lat_w_nxt;
        lat_h_r  <= lat_h_nxt;
        n_r      <= '0;
        cn_r     <= '0;
        gc_r     <= '0;
        gr_r     <= '0;
        kc_r     <= '0;
        kr_r     <= '0;
        active_r <= 1'b1;
      end

      if (state_r == ST_READ) begin
        total_r <= NW'(lat_w_r) * NW'(lat_h_r);
      end

      // advance the position counters once the item is done
      if (finish) begin
        n_r  <= n_r + NW'(1);
        cn_r <= cn_last ? '0 : cn_r + AW'(1);
        if (gval) begin
          gc_r <= gc_last ? '0 : gc_r + AW'(1);
          if (gc_last) gr_r <= gr_r + GRW'(1);
        end
      end

      if (load_out) begin
        kc_r <= kc_last ? '0 : kc_r + AW'(1);
        if (kc_last) kr_r <= kr_r + HW'(1);
        if (k_last) active_r <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix_r <= in_drain ? '0 : in_pixel_value;
    end
    if (load_out) begin
      out_mag_r  <= edge_mag;
      out_dir_r  <= edge_dir;
      out_last_r <= k_last;
    end
  end

  egnms_grad #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_grad (
    .clk      (clk),
    .rd_en    (state_r == ST_READ),
    .shift    (state_r == ST_PIX),
    .calc     (state_r == ST_GRAD),
    .addr     (cn_r),
    .pixel    (pix_r),
    .guard    (guard),
    .radicand (radicand),
    .dir      (grad_dir)
  );

  egnms_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_START),
    .radicand (radicand),
    .root     (root),
    .done     (sq_done)
  );

  egnms_nms #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_nms (
    .clk      (clk),
    .rd_en    (state_r == ST_READ),
    .shift    (state_r == ST_MAG),
    .addr     (gc_r),
    .mag      (root),
    .dir      (grad_dir),
    .interior (interior),
    .edge_mag (edge_mag),
    .edge_dir (edge_dir)
  );

  assign out_valid          = out_valid_r;
  assign out_edge_magnitude = out_mag_r;
  assign out_direction      = out_dir_r;
  assign out_last_of_frame  = out_last_r;

endmodule

// ----- tb/edge_gradient_nonmax_suppress_core_test.sv -----
// Self-checking testbench for edge_gradient_nonmax_suppress_core: raster frames in, edge results out.
// A bit-exact predictor runs beside the block. Depends on egnms_pkg and the core RTL.
module edge_gradient_nonmax_suppress_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW     = 1024;
  localparam int RING     = 4 * MAXW + 8;
  localparam int WD_LIMIT = 4000;

  localparam int MAG_W      = egnms_pkg::MAG_W;
  localparam int DIR_W      = egnms_pkg::DIR_W;
  localparam int PIX_W      = egnms_pkg::PIX_W;
  localparam int CFG_DATA_W = egnms_pkg::CFG_DATA_W;
  localparam int CFG_W_W    = egnms_pkg::CFG_W_W;
  localparam int HGT_W      = egnms_pkg::HGT_W;
  localparam int MIN_DIM    = egnms_pkg::MIN_DIM;

  localparam logic [0:0] REG_FRAME_WIDTH  = egnms_pkg::REG_FRAME_WIDTH;
  localparam logic [0:0] REG_FRAME_HEIGHT = egnms_pkg::REG_FRAME_HEIGHT;

  localparam logic [DIR_W-1:0] DIR_0   = egnms_pkg::DIR_0;
  localparam logic [DIR_W-1:0] DIR_45  = egnms_pkg::DIR_45;
  localparam logic [DIR_W-1:0] DIR_90  = egnms_pkg::DIR_90;
  localparam logic [DIR_W-1:0] DIR_135 = egnms_pkg::DIR_135;

  typedef struct {
    logic [MAG_W-1:0] mag;
    logic [DIR_W-1:0] dir;
    logic             last;
  } edge_result_t;

  typedef struct {
    bit               drain;
    logic [PIX_W-1:0] pix;
    bit               typed;
    edge_result_t     res;
  } stim_row_t;

  logic                  clk, rst_n;
  logic                  cfg_we;
  logic [0:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid, in_ready, in_drain;
  logic [PIX_W-1:0]      in_pixel_value;
  logic                  out_valid, out_ready, out_last_of_frame;
  logic [MAG_W-1:0]      out_edge_magnitude;
  logic [DIR_W-1:0]      out_direction;

  edge_gradient_nonmax_suppress_core #(.MAX_WIDTH(MAXW)) uut (.*);

  // predictor state
  logic [PIX_W-1:0] pix_ring [RING];
  int unsigned      cfg_w, cfg_h, lat_w, lat_h, in_cnt, out_cnt;
  bit               frame_open;

  edge_result_t pending_q[$];
  int           errors;
  int           pixels_sent;
  int           idle_cycles;

  function automatic longint pix_at(int unsigned r, int unsigned c);
    return longint'(pix_ring[(r * lat_w + c) % RING]);
  endfunction

  function automatic void gradient(int unsigned r, int unsigned c,
                                   output longint gx, output longint gy);
    gx = (c > 0 && c + 1 < lat_w) ? pix_at(r, c + 1) - pix_at(r, c - 1) : 0;
    gy = (r > 0 && r + 1 < lat_h) ? pix_at(r + 1, c) - pix_at(r - 1, c) : 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic int unsigned magnitude(int unsigned r, int unsigned c);
    longint gx, gy;
    longint unsigned m;
    gradient(r, c, gx, gy);
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    m = int_sqrt(longint'(gx * gx + gy * gy));
    return (m > 8191) ? 8191 : int'(m);
  endfunction

  function automatic logic [DIR_W-1:0] sector(int unsigned r, int unsigned c);
    longint gx, gy, u, v, au, av;
    gradient(r, c, gx, gy);
    u = -gy;
    v = gx;
    if (u < 0) begin
      u = -u;
      v = -v;
    end
    if (u == 0) return DIR_0;
    if (v == 0) return DIR_90;
    au = u;
    av = (v < 0) ? -v : v;
    if ((au + av) * (au + av) <= 2 * av * av) return DIR_0;
    if (au <= av || (au - av) * (au - av) <= 2 * av * av)
      return (v > 0) ? DIR_45 : DIR_135;
    return DIR_90;
  endfunction

  function automatic edge_result_t suppress_at(int unsigned k);
    edge_result_t res;
    int unsigned r, c, m, m1, m2;
    r = k / lat_w;
    c = k % lat_w;
    m = magnitude(r, c);
    res.dir = sector(r, c);
    if (r > 0 && r + 1 < lat_h && c > 0 && c + 1 < lat_w) begin
      case (res.dir)
        DIR_0: begin
          m1 = magnitude(r, c + 1);
          m2 = magnitude(r, c - 1);
        end
        DIR_45: begin
          m1 = magnitude(r - 1, c + 1);
          m2 = magnitude(r + 1, c - 1);
        end
        DIR_90: begin
          m1 = magnitude(r - 1, c);
          m2 = magnitude(r + 1, c);
        end
        default: begin
          m1 = magnitude(r - 1, c - 1);
          m2 = magnitude(r + 1, c + 1);
        end
      endcase
      if (!(m > m1 && m > m2)) m = 0;
    end
    res.mag  = m[MAG_W-1:0];
    res.last = (k + 1 == lat_w * lat_h);
    return res;
  endfunction

  // advance the predictor by one transfer; returns 1 when a result is due
  function automatic bit edge_step(bit drain, logic [PIX_W-1:0] pix, output edge_result_t res);
    res = '{default: '0};
    if (!drain) begin
      if (!frame_open || in_cnt >= lat_w * lat_h) begin
        lat_w = (cfg_w < MIN_DIM) ? MIN_DIM : ((cfg_w > MAXW) ? MAXW : cfg_w);
        lat_h = (cfg_h < MIN_DIM) ? MIN_DIM : cfg_h;
        in_cnt = 0;
        out_cnt = 0;
        frame_open = 1;
      end
      pix_ring[in_cnt % RING] = pix;
      in_cnt++;
      if (in_cnt - 1 - out_cnt == 2 * lat_w + 2) begin
        res = suppress_at(out_cnt);
        out_cnt++;
        return 1;
      end
      return 0;
    end
    if (frame_open && in_cnt >= lat_w * lat_h && out_cnt < lat_w * lat_h) begin
      res = suppress_at(out_cnt);
      out_cnt++;
      if (out_cnt >= lat_w * lat_h) frame_open = 0;
      return 1;
    end
    return 0;
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // sender burst control
  int burst_left;

  task automatic send_item(bit drain, logic [PIX_W-1:0] pix, bit typed, edge_result_t typed_res);
    edge_result_t res;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid       <= 1'b1;
    in_drain       <= drain;
    in_pixel_value <= pix;
    do @(posedge clk); while (!in_ready);
    if (edge_step(drain, pix, res)) pending_q.push_back(typed ? typed_res : res);
    if (!drain) pixels_sent++;
  endtask

  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    // drop any trailing ignored drains still inside the block
    repeat (60) @(negedge clk);
  endtask

  task automatic write_frame_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_w = w[CFG_W_W-1:0];
    cfg_h = h[HGT_W-1:0];
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 3))
      0: return PIX_W'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? {PIX_W{1'b1}} : '0;
      2: return PIX_W'($urandom_range(100, 106));
      default: return PIX_W'($urandom_range(2040, 2056));
    endcase
  endfunction

  // one frame, optionally cut short so the next frame drops its tail
  task automatic run_frame(int unsigned npix, bit full_flush);
    edge_result_t none;
    int cut;
    none = '{default: '0};
    for (int unsigned i = 0; i < npix; i++) begin
      if (i > 0 && $urandom_range(0, 31) == 0) send_item(1'b1, PIX_W'($urandom), 1'b0, none);
      send_item(1'b0, pick_pixel(), 1'b0, none);
    end
    if (full_flush) begin
      while (frame_open) send_item(1'b1, PIX_W'($urandom), 1'b0, none);
      repeat ($urandom_range(0, 2)) send_item(1'b1, PIX_W'($urandom), 1'b0, none);
    end else begin
      cut = $urandom_range(0, 2 * lat_w + 1);
      repeat (cut) send_item(1'b1, PIX_W'($urandom), 1'b0, none);
    end
  endtask

  stim_row_t dir_rows[$];

  task automatic add_row(bit drain, logic [PIX_W-1:0] pix, bit typed,
                         logic [MAG_W-1:0] mag, logic [DIR_W-1:0] dir, logic last);
    stim_row_t row;
    row.drain = drain;
    row.pix   = pix;
    row.typed = typed;
    row.res   = '{mag: mag, dir: dir, last: last};
    dir_rows.push_back(row);
  endtask

  // receiver stall pattern
  int rx_mode, rx_left, rx_hold;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 400);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold == 0) rx_hold = $urandom_range(1, 30);
        rx_hold--;
        out_ready <= (rx_hold == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    edge_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result mag=%0d dir=%0d last=%0b", $realtime,
                 out_edge_magnitude, out_direction, out_last_of_frame);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_edge_magnitude !== want.mag) begin
          $display("%0t: edge_magnitude expected %0d actual %0d", $realtime,
                   want.mag, out_edge_magnitude);
          errors++;
        end
        if (out_direction !== want.dir) begin
          $display("%0t: direction expected %0d actual %0d", $realtime,
                   want.dir, out_direction);
          errors++;
        end
        if (out_last_of_frame !== want.last) begin
          $display("%0t: last_of_frame expected %0b actual %0b", $realtime,
                   want.last, out_last_of_frame);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("edge_gradient_nonmax_suppress_core: mismatch");
      $finish;
    end
  end

  initial begin
    bit last_partial, full;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    in_valid = 0;
    in_drain = 0;
    in_pixel_value = '0;
    pixels_sent = 0;
    burst_left = 0;
    cfg_w = 512;
    cfg_h = 512;
    lat_w = 3;
    lat_h = 3;
    in_cnt = 0;
    out_cnt = 0;
    frame_open = 0;
    foreach (pix_ring[i]) pix_ring[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    write_frame_size(CFG_DATA_W'(3), CFG_DATA_W'(3));

    // directed: stray drain, flat bright 3x3 frame, its flush, another stray drain, then a contrasty frame
    add_row(1'b1, 12'h000, 1'b0, '0, DIR_0, 1'b0);
    for (int i = 0; i < 9; i++) add_row(1'b0, 12'hFFF, i == 8, '0, DIR_0, 1'b0);
    for (int i = 0; i < 8; i++) add_row(1'b1, 12'h000, 1'b1, '0, DIR_0, i == 7);
    add_row(1'b1, 12'hFFF, 1'b0, '0, DIR_0, 1'b0);
    add_row(1'b0, 12'h000, 1'b0, '0, DIR_0, 1'b0);
    add_row(1'b0, 12'hFFF, 1'b0, '0, DIR_0, 1'b0);
    add_row(1'b0, 12'h000, 1'b0, '0, DIR_0, 1'b0);
    add_row(1'b0, 12'hFFF, 1'b0, '0, DIR_0, 1'b0);
    add_row(1'b0, 12'h000, 1'b0, '0, DIR_0, 1'b0);
    add_row(1'b0, 12'h000, 1'b0, '0, DIR_0, 1'b0);
    add_row(1'b0, 12'h000, 1'b0, '0, DIR_0, 1'b0);
    add_row(1'b0, 12'h555, 1'b0, '0, DIR_0, 1'b0);
    add_row(1'b0, 12'hAAA, 1'b0, '0, DIR_0, 1'b0);
    foreach (dir_rows[i])
      send_item(dir_rows[i].drain, dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].res);

    // random frames; a cut flush leaves the tail for the next frame to drop
    last_partial = 1;
    while (pixels_sent < 1150 || last_partial) begin
      if (!last_partial) begin
        settle_idle();
        write_frame_size(CFG_DATA_W'($urandom_range(3, 10)), CFG_DATA_W'($urandom_range(3, 8)));
      end
      full = !(pixels_sent < 1000 && $urandom_range(0, 4) == 0);
      run_frame(((cfg_w < 3) ? 3 : cfg_w) * ((cfg_h < 3) ? 3 : cfg_h), full);
      last_partial = !full;
    end

    // register extreme: both sizes below minimum
    settle_idle();
    write_frame_size(CFG_DATA_W'(0), CFG_DATA_W'(0));
    run_frame(9, 1'b1);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("edge_gradient_nonmax_suppress_core: match");
    else $display("edge_gradient_nonmax_suppress_core: mismatch");
    $finish;
  end

endmodule
